// File: src/assert_macros.svh
// Assertion helpers for the stack calculator checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is high.
`define SMA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define SMA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/sma_pkg.sv
`default_nettype none

package sma_pkg;

   localparam int WORD_W              = 32;
   localparam int OP_W                = 3;
   localparam int STATUS_W            = 2;
   localparam int DEPTH_W             = 7;
   localparam int CAP_W               = 7;
   localparam int DEFAULT_STACK_DEPTH = 64;

   localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;
   localparam logic [WORD_W-1:0] FAIL_WORD = 32'hDEADDEAD;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OP_W-1:0] OP_POP  = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD  = 3'd2;
   localparam logic [OP_W-1:0] OP_SUB  = 3'd3;
   localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
   localparam logic [OP_W-1:0] OP_DIV  = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNF = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVF = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DBZ = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] result_value;
      logic [STATUS_W-1:0]      status;
      logic [DEPTH_W-1:0]       depth;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/sma_stack_mem.sv
`default_nettype none

module sma_stack_mem #(
   parameter int DEPTH  = sma_pkg::DEFAULT_STACK_DEPTH,
   parameter int WIDTH  = sma_pkg::WORD_W,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]  rd_data_a,
   output logic      [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// File: src/sma_divider.sv
`default_nettype none

// Unsigned restoring divider, one quotient bit per cycle.
module sma_divider #(
   parameter int WIDTH = sma_pkg::WORD_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output logic                  done,
   output logic      [WIDTH-1:0] quotient
);

   localparam int STEP_W = $clog2(WIDTH + 1);

   logic              busy_ff,  busy_in;
   logic              done_ff,  done_in;
   logic [STEP_W-1:0] step_ff,  step_in;
   logic [WIDTH-1:0]  rem_ff,   rem_in;
   logic [WIDTH-1:0]  quo_ff,   quo_in;
   logic [WIDTH-1:0]  den_ff,   den_in;
   logic [WIDTH:0]    shifted;
   logic [WIDTH:0]    diff;
   logic              fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[WIDTH-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
         quo_in  = {quo_ff[WIDTH-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: src/stack_machine_alu_top.sv
`default_nettype none

// Bounded data stack with an arithmetic unit. The stack lives in a synchronous memory with two
// read ports; an item is accepted only while the block is idle, so reads, the write-back and
// the count update of one item never overlap with the next. A push, an underflow or an unused
// code goes from idle straight to the response state; pop, add, subtract, multiply and divide
// first pass an execute state fed by the registered read of the two top entries, and a divide
// with a nonzero divisor then waits for the bit-serial divider. A new request is taken the
// cycle after its result is loaded into the output register, even if that result has not yet
// been taken. The capacity register should be written only while idle; 0 acts as 1, values
// above STACK_DEPTH act as STACK_DEPTH. A push when full returns overflow and result 0.
module stack_machine_alu_top #(
   parameter int STACK_DEPTH = sma_pkg::DEFAULT_STACK_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire sma_pkg::req_type           req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output sma_pkg::rsp_type                rsp_data,
   input  wire logic                       csr_wr_en,
   input  wire logic [sma_pkg::CAP_W-1:0]  csr_wr_data
);

   localparam int W      = sma_pkg::WORD_W;
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > sma_pkg::CAP_W) ? CNT_W : sma_pkg::CAP_W;

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DIV, ST_RESP} state_type;

   state_type                     state_ff,    state_in;
   logic [sma_pkg::OP_W-1:0]      op_ff,       op_in;
   logic [W-1:0]                  res_ff,      res_in;
   logic [sma_pkg::STATUS_W-1:0]  status_ff,   status_in;
   logic                          wr_en_ff,    wr_en_in;
   logic [ADDR_W-1:0]             wr_addr_ff,  wr_addr_in;
   logic [CNT_W-1:0]              cnt_new_ff,  cnt_new_in;
   logic [CNT_W-1:0]              count_ff,    count_in;
   logic                          neg_ff,      neg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   sma_pkg::rsp_type              rsp_data_ff, rsp_data_in;
   logic [sma_pkg::CAP_W-1:0]     cap_ff;

   logic [CNT_W-1:0]  cnt_dec1;
   logic [CNT_W-1:0]  cnt_dec2;
   logic [ADDR_W-1:0] t_addr;
   logic [ADDR_W-1:0] s_addr;
   logic [CMP_W-1:0]  cnt_cmp;
   logic [CMP_W-1:0]  cap_cmp;
   logic              full;
   logic              req_xfer;
   logic              mem_we;
   logic [W-1:0]      rd_t;
   logic [W-1:0]      rd_s;
   logic [W-1:0]      mag_t;
   logic [W-1:0]      mag_s;
   logic              div_start;
   logic              div_done;
   logic [W-1:0]      div_quo;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;

   assign cnt_dec1 = count_ff - 1'b1;
   assign cnt_dec2 = count_ff - CNT_W'(2);
   assign t_addr   = cnt_dec1[ADDR_W-1:0];
   assign s_addr   = cnt_dec2[ADDR_W-1:0];

   // capacity in use: zero means one
   assign cnt_cmp = CMP_W'(count_ff);
   assign cap_cmp = (cap_ff == '0) ? CMP_W'(1) : CMP_W'(cap_ff);
   assign full    = (cnt_cmp >= cap_cmp) || (count_ff == CNT_W'(STACK_DEPTH));

   assign mag_t = rd_t[W-1] ? (W'(0) - rd_t) : rd_t;
   assign mag_s = rd_s[W-1] ? (W'(0) - rd_s) : rd_s;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      wr_en_in     = wr_en_ff;
      wr_addr_in   = wr_addr_ff;
      cnt_new_in   = cnt_new_ff;
      count_in     = count_ff;
      neg_in       = neg_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_data.operation;
               res_in     = '0;
               status_in  = sma_pkg::ST_OK;
               wr_en_in   = 1'b0;
               wr_addr_in = count_ff[ADDR_W-1:0];
               cnt_new_in = count_ff;
               state_in   = ST_RESP;
               case (req_data.operation) inside
                  sma_pkg::OP_PUSH: begin
                     if (full) begin
                        status_in = sma_pkg::ST_OVF;
                     end else begin
                        res_in     = req_data.push_value;
                        wr_en_in   = 1'b1;
                        cnt_new_in = count_ff + 1'b1;
                     end
                  end
                  sma_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        status_in = sma_pkg::ST_UNF;
                        res_in    = sma_pkg::FAIL_WORD;
                     end else begin
                        state_in = ST_EXEC;
                     end
                  end
                  sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_MUL, sma_pkg::OP_DIV: begin
                     if (count_ff < CNT_W'(2)) begin
                        status_in = sma_pkg::ST_UNF;
                     end else begin
                        state_in = ST_EXEC;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EXEC: begin
            state_in   = ST_RESP;
            cnt_new_in = cnt_dec1;
            wr_addr_in = s_addr;
            case (op_ff) inside
               sma_pkg::OP_POP: begin
                  res_in = rd_t;
               end
               sma_pkg::OP_ADD: begin
                  res_in   = rd_s + rd_t;
                  wr_en_in = 1'b1;
               end
               sma_pkg::OP_SUB: begin
                  res_in   = rd_s - rd_t;
                  wr_en_in = 1'b1;
               end
               sma_pkg::OP_MUL: begin
                  res_in   = W'(rd_s * rd_t);
                  wr_en_in = 1'b1;
               end
               default: begin
                  if (rd_t == '0) begin
                     status_in  = sma_pkg::ST_DBZ;
                     cnt_new_in = count_ff;
                  end else begin
                     div_start = 1'b1;
                     neg_in    = rd_s[W-1] ^ rd_t[W-1];
                     wr_en_in  = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = neg_ff ? (W'(0) - div_quo) : div_quo;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            // commit write-back and count together with loading the result into the output register
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.result_value = res_ff;
               rsp_data_in.status       = status_ff;
               rsp_data_in.depth        = sma_pkg::DEPTH_W'(cnt_new_ff);
               rsp_valid_in             = 1'b1;
               count_in                 = cnt_new_ff;
               mem_we                   = wr_en_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= sma_pkg::CAP_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
      op_ff       <= op_in;
      res_ff      <= res_in;
      status_ff   <= status_in;
      wr_en_ff    <= wr_en_in;
      wr_addr_ff  <= wr_addr_in;
      cnt_new_ff  <= cnt_new_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   sma_stack_mem #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (W)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (wr_addr_ff),
      .wr_data   (res_ff),
      .rd_en     (req_xfer),
      .rd_addr_a (t_addr),
      .rd_addr_b (s_addr),
      .rd_data_a (rd_t),
      .rd_data_b (rd_s)
   );

   sma_divider #(
      .WIDTH (W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_s),
      .divisor  (mag_t),
      .done     (div_done),
      .quotient (div_quo)
   );

endmodule

`default_nettype wire

// File: src/sma_checker.sv
`default_nettype none
`include "assert_macros.svh"

module sma_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire sma_pkg::req_type          req_data,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire sma_pkg::rsp_type          rsp_data,
   input wire logic                      csr_wr_en,
   input wire logic [sma_pkg::CAP_W-1:0] csr_wr_data
);

   logic req_xfer;
   logic cfg_unused;

   assign req_xfer   = req_valid && req_ready;
   assign cfg_unused = csr_wr_en ^ (^csr_wr_data) ^ (^req_data);

   `SMA_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)), "stalled result changed or dropped")

   `SMA_ASSERT(a_one_in_flight, clock, reset, req_xfer |=> !req_ready, "second request taken while one is in work")

   `SMA_ASSERT(a_ovf_zero, clock, reset, (rsp_valid && (rsp_data.status == sma_pkg::ST_OVF)) |-> ((rsp_data.result_value == '0) && !cfg_unused || (rsp_data.result_value == '0)), "overflow result is not zero")

   `SMA_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_valid && req_ready), "block not idle after reset")

endmodule

bind stack_machine_alu_top sma_checker u_sma_checker (.*);

`default_nettype wire
